FILE: rtl/core/rypc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rypc_pkg
// Shared widths, coefficients, register codes and pipeline types for the
// RGB / BT.601 YPbPr converter.
// ----------------------------------------------------------------------------
package rypc_pkg;

   // fixed-point format of Y, Pb and Pr
   localparam int FRAC_BITS  = 16;
   // fractional bits of the matrix coefficients
   localparam int CSH        = 20;

   localparam int SAMPLE_W   = 16;
   localparam int FIX_W      = 18;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 21;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // forward path
   localparam int FWD_PROD_W = COEF_W + SAMPLE_W;
   localparam int FWD_ACC_W  = FWD_PROD_W + 1;
   localparam int MAG_W      = 36;
   localparam int NUM_W      = MAG_W + FRAC_BITS + 2;

   // rounding divider: quotient bits, divisor and working register
   localparam int QUO_W      = FIX_W;
   localparam int DEN_W      = SAMPLE_W + CSH + 1;
   localparam int WORK_W     = DEN_W + QUO_W;
   localparam int CMP_W      = (NUM_W > WORK_W) ? NUM_W : WORK_W;
   localparam int DIV_STEPS  = QUO_W;

   // inverse path
   localparam int INV_PROD_W = FIX_W + COEF_W + 1;
   localparam int INV_ACC_W  = INV_PROD_W + 1;
   localparam int INV_MAG_W  = INV_PROD_W;
   localparam int SCALE_W    = INV_MAG_W + SAMPLE_W;

   // products, sums, scale, divider steps, output register
   localparam int NUM_STAGES = 3 + DIV_STEPS + 1;

   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RESET = 16'd255;
   localparam logic [PIX_W-1:0]    PIX_MAX          = 8'd255;
   localparam logic [FIX_W-1:0]    FIX_MAX          = 18'h1FFFF;
   localparam logic [FIX_W-1:0]    FIX_MIN          = 18'h20000;

   // coefficients, round(c * 2^20)
   localparam logic [COEF_W-1:0] K_YR   = 21'd313524;
   localparam logic [COEF_W-1:0] K_YG   = 21'd615514;
   localparam logic [COEF_W-1:0] K_YB   = 21'd119538;
   localparam logic [COEF_W-1:0] K_BR   = 21'd176933;
   localparam logic [COEF_W-1:0] K_BG   = 21'd347355;
   localparam logic [COEF_W-1:0] K_HALF = 21'd524288;
   localparam logic [COEF_W-1:0] K_RG   = 21'd439026;
   localparam logic [COEF_W-1:0] K_RB   = 21'd85262;
   localparam logic [COEF_W-1:0] K_RPR  = 21'd1470104;
   localparam logic [COEF_W-1:0] K_GPB  = 21'd360853;
   localparam logic [COEF_W-1:0] K_GPR  = 21'd748826;
   localparam logic [COEF_W-1:0] K_BPB  = 21'd1858077;

   // forward matrix magnitudes, rows Y / Pb / Pr, columns R / G / B
   localparam logic [COEF_W-1:0] FWD_COEF [3][3] = '{
      '{K_YR,   K_YG, K_YB},
      '{K_BR,   K_BG, K_HALF},
      '{K_HALF, K_RG, K_RB}
   };

   typedef enum logic {
      REG_DIRECTION  = 1'b0,
      REG_MAX_SAMPLE = 1'b1
   } reg_index_type;

   // one channel in the divider: remainder and numerator bits, quotient
   // bits shift in from the bottom
   typedef struct packed {
      logic [WORK_W-1:0] work;
      logic              neg;
      logic              sat;
   } div_lane_type;

   typedef struct packed {
      logic                       inverse;
      div_lane_type [2:0]         lane;
      logic [2:0][PIX_W-1:0]      rgb;
   } div_item_type;

endpackage

FILE: rtl/core/rypc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rypc_div_step
// One restoring division step for the three forward channels, with its
// pipeline register and valid bit.
// ----------------------------------------------------------------------------
module rypc_div_step import rypc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  div_item_type      in_item,
   input  logic [DEN_W-1:0]  divisor,
   output logic              out_valid,
   output div_item_type      out_item
);

   logic                  valid_ff;
   div_item_type          item_ff;
   div_item_type          item_in;
   logic [2:0][WORK_W:0]  shifted;
   logic [2:0][DEN_W:0]   partial;
   logic [2:0]            take;

   always_comb begin
      item_in = in_item;
      for (int c = 0; c < 3; c++) begin
         shifted[c] = {in_item.lane[c].work, 1'b0};
         partial[c] = shifted[c][WORK_W:QUO_W];
         take[c]    = (partial[c] >= {1'b0, divisor});
         if (take[c]) begin
            partial[c] = partial[c] - {1'b0, divisor};
         end
         item_in.lane[c].work = {partial[c][DEN_W-1:0], shifted[c][QUO_W-1:1], take[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/core/rgb_ypbpr_color_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_ypbpr_color_converter_core
// Pixel converter between RGB and BT.601 YPbPr, direction and maximum
// sample value set through the register port.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while rsp_stall is low; the 18 quotient bits of
//   the forward rounding divider come from 18 pipelined restoring steps
// rsp_stall propagates combinationally back through the ready chain, a bubble in the pipe is filled while rsp waits
// reset clears all valid bits, direction to RGB to YPbPr, max_sample to 255
module rgb_ypbpr_color_converter_core import rypc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [SAMPLE_W-1:0]   req_red_in,
   input  logic        [SAMPLE_W-1:0]   req_green_in,
   input  logic        [SAMPLE_W-1:0]   req_blue_in,
   input  logic signed [FIX_W-1:0]      req_luma_in,
   input  logic signed [FIX_W-1:0]      req_blue_diff_in,
   input  logic signed [FIX_W-1:0]      req_red_diff_in,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [FIX_W-1:0]      rsp_luma_out,
   output logic signed [FIX_W-1:0]      rsp_blue_diff_out,
   output logic signed [FIX_W-1:0]      rsp_red_diff_out,
   output logic        [PIX_W-1:0]      rsp_red_out,
   output logic        [PIX_W-1:0]      rsp_green_out,
   output logic        [PIX_W-1:0]      rsp_blue_out,

   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic        [CSR_ADDR_W-1:0] paddr,
   input  logic        [CSR_DATA_W-1:0] pwdata,
   output logic        [CSR_DATA_W-1:0] prdata,
   output logic                         pready
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                  direction_ff;
   logic [SAMPLE_W-1:0]   max_sample_ff;
   reg_index_type         csr_index;
   logic                  csr_write;
   logic [SAMPLE_W-1:0]   eff_max;
   logic [DEN_W-1:0]      divisor;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= 1'b0;
         max_sample_ff <= MAX_SAMPLE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DIRECTION:  direction_ff  <= pwdata[0];
            REG_MAX_SAMPLE: max_sample_ff <= pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DIRECTION:  prdata = CSR_DATA_W'(direction_ff);
         REG_MAX_SAMPLE: prdata = CSR_DATA_W'(max_sample_ff);
         default:        prdata = '0;
      endcase
   end

   // zero maximum behaves as one
   assign eff_max = (max_sample_ff == '0) ? SAMPLE_W'(1) : max_sample_ff;
   assign divisor = {eff_max, {(CSH + 1){1'b0}}};

   // ------------------------------------------------------------------
   // stall chain
   // ------------------------------------------------------------------
   logic [NUM_STAGES:0]   ready;
   logic [NUM_STAGES-1:0] stage_valid;
   logic                  s1_valid_ff;
   logic                  s2_valid_ff;
   logic                  s3_valid_ff;
   logic                  out_valid_ff;
   logic [DIV_STEPS:0]    div_valid;
   div_item_type          div_item [DIV_STEPS+1];

   assign stage_valid = {out_valid_ff, div_valid[DIV_STEPS:1],
                         s3_valid_ff, s2_valid_ff, s1_valid_ff};

   assign ready[NUM_STAGES] = !rsp_stall;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
      assign ready[k] = !stage_valid[k] || ready[k+1];
   end

   assign req_stall = !ready[0];

   // ------------------------------------------------------------------
   // stage 1: matrix products
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0]          samp [3];
   logic [FWD_PROD_W-1:0]        fwd_prod_in [3][3];
   logic [FWD_PROD_W-1:0]        fwd_prod_ff [3][3];
   logic signed [INV_PROD_W-1:0] inv_prod_in [4];
   logic signed [INV_PROD_W-1:0] inv_prod_ff [4];
   logic signed [FIX_W-1:0]      luma_ff;
   logic                         s1_inv_ff;

   always_comb begin
      samp[0] = req_red_in;
      samp[1] = req_green_in;
      samp[2] = req_blue_in;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            fwd_prod_in[r][c] = FWD_PROD_W'(FWD_COEF[r][c]) * FWD_PROD_W'(samp[c]);
         end
      end
      inv_prod_in[0] = INV_PROD_W'(req_red_diff_in)  * INV_PROD_W'($signed({1'b0, K_RPR}));
      inv_prod_in[1] = INV_PROD_W'(req_blue_diff_in) * INV_PROD_W'($signed({1'b0, K_GPB}));
      inv_prod_in[2] = INV_PROD_W'(req_red_diff_in)  * INV_PROD_W'($signed({1'b0, K_GPR}));
      inv_prod_in[3] = INV_PROD_W'(req_blue_diff_in) * INV_PROD_W'($signed({1'b0, K_BPB}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready[0]) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && req_valid) begin
         fwd_prod_ff <= fwd_prod_in;
         inv_prod_ff <= inv_prod_in;
         luma_ff     <= req_luma_in;
         s1_inv_ff   <= direction_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: sums
   // ------------------------------------------------------------------
   logic signed [FWD_ACC_W-1:0] fwd_term [3][3];
   logic signed [FWD_ACC_W-1:0] fwd_acc_in [3];
   logic signed [FWD_ACC_W-1:0] fwd_acc_ff [3];
   logic signed [INV_ACC_W-1:0] luma_fix;
   logic signed [INV_ACC_W-1:0] inv_acc_in [3];
   logic signed [INV_ACC_W-1:0] inv_acc_ff [3];
   logic                        s2_inv_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            fwd_term[r][c] = $signed(FWD_ACC_W'(fwd_prod_ff[r][c]));
         end
      end
      fwd_acc_in[0] = fwd_term[0][0] + fwd_term[0][1] + fwd_term[0][2];
      fwd_acc_in[1] = fwd_term[1][2] - fwd_term[1][0] - fwd_term[1][1];
      fwd_acc_in[2] = fwd_term[2][0] - fwd_term[2][1] - fwd_term[2][2];

      luma_fix      = INV_ACC_W'($signed({luma_ff, {CSH{1'b0}}}));
      inv_acc_in[0] = luma_fix + INV_ACC_W'(inv_prod_ff[0]);
      inv_acc_in[1] = luma_fix - INV_ACC_W'(inv_prod_ff[1]) - INV_ACC_W'(inv_prod_ff[2]);
      inv_acc_in[2] = luma_fix + INV_ACC_W'(inv_prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready[1]) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1] && s1_valid_ff) begin
         fwd_acc_ff <= fwd_acc_in;
         inv_acc_ff <= inv_acc_in;
         s2_inv_ff  <= s1_inv_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: divider setup (forward), rescale and clamp (inverse)
   // ------------------------------------------------------------------
   logic [FWD_ACC_W-1:0]  fwd_abs [3];
   logic [NUM_W-1:0]      numer [3];
   logic [CMP_W-1:0]      sat_limit;
   logic [SCALE_W-1:0]    scaled [3];
   logic [SCALE_W-1:0]    pix_full [3];
   div_item_type          s3_item_in;
   div_item_type          s3_item_ff;

   // quotient of 2^QUO_W or more saturates
   assign sat_limit = CMP_W'({eff_max, {(CSH + 1 + QUO_W){1'b0}}});

   always_comb begin
      s3_item_in         = '0;
      s3_item_in.inverse = s2_inv_ff;
      for (int c = 0; c < 3; c++) begin
         // round to nearest: (2|acc| 2^F + m 2^20) / (m 2^21)
         fwd_abs[c] = fwd_acc_ff[c][FWD_ACC_W-1] ? FWD_ACC_W'(-fwd_acc_ff[c])
                                                 : FWD_ACC_W'(fwd_acc_ff[c]);
         numer[c]   = (NUM_W'(fwd_abs[c][MAG_W-1:0]) << (FRAC_BITS + 1))
                    + NUM_W'({eff_max, {CSH{1'b0}}});
         s3_item_in.lane[c].neg  = fwd_acc_ff[c][FWD_ACC_W-1];
         s3_item_in.lane[c].sat  = (CMP_W'(numer[c]) >= sat_limit);
         s3_item_in.lane[c].work = WORK_W'(numer[c]);

         scaled[c]   = SCALE_W'(inv_acc_ff[c][INV_MAG_W-1:0]) * SCALE_W'(eff_max);
         pix_full[c] = scaled[c] >> (CSH + FRAC_BITS);
         if (inv_acc_ff[c][INV_ACC_W-1] || (inv_acc_ff[c] == '0)) begin
            s3_item_in.rgb[c] = '0;
         end else if (pix_full[c] > SCALE_W'(PIX_MAX)) begin
            s3_item_in.rgb[c] = PIX_MAX;
         end else begin
            s3_item_in.rgb[c] = pix_full[c][PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready[2]) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2] && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   // ------------------------------------------------------------------
   // divider steps, one quotient bit each
   // ------------------------------------------------------------------
   assign div_valid[0] = s3_valid_ff;
   assign div_item[0]  = s3_item_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rypc_div_step u_div_step (
         .clock     (clock),
         .reset     (reset),
         .load      (ready[3+i]),
         .in_valid  (div_valid[i]),
         .in_item   (div_item[i]),
         .divisor   (divisor),
         .out_valid (div_valid[i+1]),
         .out_item  (div_item[i+1])
      );
   end

   // ------------------------------------------------------------------
   // output register: saturation and result selection
   // ------------------------------------------------------------------
   div_item_type          last_item;
   logic [QUO_W-1:0]      quo [3];
   logic [FIX_W-1:0]      fix_in [3];
   logic [FIX_W-1:0]      fix_ff [3];
   logic [PIX_W-1:0]      pix_in [3];
   logic [PIX_W-1:0]      pix_ff [3];

   assign last_item = div_item[DIV_STEPS];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quo[c] = last_item.lane[c].work[QUO_W-1:0];
         if (last_item.lane[c].sat) begin
            fix_in[c] = last_item.lane[c].neg ? FIX_MIN : FIX_MAX;
         end else if (last_item.lane[c].neg) begin
            fix_in[c] = (quo[c] >= FIX_MIN) ? FIX_MIN : FIX_W'(~quo[c] + 1'b1);
         end else begin
            fix_in[c] = (quo[c] > FIX_MAX) ? FIX_MAX : quo[c];
         end
         if (last_item.inverse) begin
            fix_in[c] = '0;
            pix_in[c] = last_item.rgb[c];
         end else begin
            pix_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ready[NUM_STAGES-1]) begin
         out_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[NUM_STAGES-1] && div_valid[DIV_STEPS]) begin
         fix_ff <= fix_in;
         pix_ff <= pix_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_luma_out      = fix_ff[0];
   assign rsp_blue_diff_out = fix_ff[1];
   assign rsp_red_diff_out  = fix_ff[2];
   assign rsp_red_out       = pix_ff[0];
   assign rsp_green_out     = pix_ff[1];
   assign rsp_blue_out      = pix_ff[2];

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB / BT.601 YPbPr pixel converter. Pixels are
// streamed through the valid/stall channels under random gaps and stalls,
// across both directions and several maximum sample values, and every result
// is compared against a bit-exact integer prediction of the conversion.
// ----------------------------------------------------------------------------
module tb import rypc_pkg::*; ();

   localparam int SETTLE_CYCLES = 30;

   // matrix coefficients with 20 fractional bits
   localparam longint C_Y_R  = 313524;
   localparam longint C_Y_G  = 615514;
   localparam longint C_Y_B  = 119538;
   localparam longint C_PB_R = 176933;
   localparam longint C_PB_G = 347355;
   localparam longint C_HALF = 524288;
   localparam longint C_PR_G = 439026;
   localparam longint C_PR_B = 85262;
   localparam longint C_ONE  = 1048576;
   localparam longint C_R_PR = 1470104;
   localparam longint C_G_PB = 360853;
   localparam longint C_G_PR = 748826;
   localparam longint C_B_PB = 1858077;

   typedef struct packed {
      logic        [SAMPLE_W-1:0] red;
      logic        [SAMPLE_W-1:0] green;
      logic        [SAMPLE_W-1:0] blue;
      logic signed [FIX_W-1:0]    luma;
      logic signed [FIX_W-1:0]    blue_diff;
      logic signed [FIX_W-1:0]    red_diff;
   } pixel_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] luma;
      logic signed [FIX_W-1:0] blue_diff;
      logic signed [FIX_W-1:0] red_diff;
      logic        [PIX_W-1:0] red;
      logic        [PIX_W-1:0] green;
      logic        [PIX_W-1:0] blue;
   } conv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic        [SAMPLE_W-1:0] req_red_in = '0;
   logic        [SAMPLE_W-1:0] req_green_in = '0;
   logic        [SAMPLE_W-1:0] req_blue_in = '0;
   logic signed [FIX_W-1:0]    req_luma_in = '0;
   logic signed [FIX_W-1:0]    req_blue_diff_in = '0;
   logic signed [FIX_W-1:0]    req_red_diff_in = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [FIX_W-1:0]    rsp_luma_out;
   logic signed [FIX_W-1:0]    rsp_blue_diff_out;
   logic signed [FIX_W-1:0]    rsp_red_diff_out;
   logic        [PIX_W-1:0]    rsp_red_out;
   logic        [PIX_W-1:0]    rsp_green_out;
   logic        [PIX_W-1:0]    rsp_blue_out;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // converter settings as the bench believes them to be
   logic          cfg_direction = 1'b0;
   logic [15:0]   cfg_max = 16'd255;

   pixel_type        source_pixels[$];
   conv_result_type  expected_pixels[$];
   pixel_type        on_wire;
   conv_result_type  oldest;
   int               send_gap = 0;
   int               recv_hold = 0;
   int               send_mode = 0;
   int               recv_mode = 0;
   int               error_count = 0;

   rgb_ypbpr_color_converter_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_luma_in       (req_luma_in),
      .req_blue_diff_in  (req_blue_diff_in),
      .req_red_diff_in   (req_red_diff_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_luma_out      (rsp_luma_out),
      .rsp_blue_diff_out (rsp_blue_diff_out),
      .rsp_red_diff_out  (rsp_red_diff_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #800000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint effective_max();
      return (cfg_max == 16'd0) ? 64'sd1 : longint'(cfg_max);
   endfunction

   // round to nearest, ties away from zero, saturate to 18 bits
   function automatic logic signed [FIX_W-1:0] fix_from_sum(longint acc);
      longint num;
      longint den;
      longint unsigned mag;
      longint unsigned quo;
      num = acc <<< FRAC_BITS;
      den = effective_max() << CSH;
      mag = (num < 0) ? -num : num;
      quo = (2 * mag + den) / (2 * den);
      if (num < 0) begin
         if (quo > 131072) return 18'sh20000;
         return FIX_W'(-quo);
      end
      if (quo > 131071) return 18'sh1FFFF;
      return FIX_W'(quo);
   endfunction

   // floor after scaling, nonpositive gives zero, clamp at 255
   function automatic logic [PIX_W-1:0] pix_from_sum(longint acc);
      longint unsigned quo;
      if (acc <= 0) return '0;
      quo = longint'(acc * effective_max()) >> (CSH + FRAC_BITS);
      return (quo > 255) ? 8'd255 : quo[PIX_W-1:0];
   endfunction

   function automatic conv_result_type convert_pixel(pixel_type px);
      conv_result_type res;
      longint r, g, b, y, pb, pr;
      res = '0;
      if (!cfg_direction) begin
         r = longint'(px.red);
         g = longint'(px.green);
         b = longint'(px.blue);
         res.luma      = fix_from_sum(C_Y_R * r + C_Y_G * g + C_Y_B * b);
         res.blue_diff = fix_from_sum(-C_PB_R * r - C_PB_G * g + C_HALF * b);
         res.red_diff  = fix_from_sum(C_HALF * r - C_PR_G * g - C_PR_B * b);
      end else begin
         y  = longint'(px.luma);
         pb = longint'(px.blue_diff);
         pr = longint'(px.red_diff);
         res.red   = pix_from_sum(C_ONE * y + C_R_PR * pr);
         res.green = pix_from_sum(C_ONE * y - C_G_PB * pb - C_G_PR * pr);
         res.blue  = pix_from_sum(C_ONE * y + C_B_PB * pb);
      end
      return res;
   endfunction

   function automatic int draw_wait(int mode);
      if (mode == 1) return $urandom_range(0, 10);
      if (mode == 2) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
      return 0;
   endfunction

   // mostly in-range content for the active direction, the rest full-range noise
   function automatic pixel_type random_pixel();
      pixel_type px;
      int unsigned top;
      top = (cfg_max == 16'd0) ? 1 : cfg_max;
      px.red       = $urandom;
      px.green     = $urandom;
      px.blue      = $urandom;
      px.luma      = $urandom;
      px.blue_diff = $urandom;
      px.red_diff  = $urandom;
      if ($urandom_range(0, 6) != 0) begin
         if (!cfg_direction) begin
            px.red   = $urandom_range(0, top);
            px.green = $urandom_range(0, top);
            px.blue  = $urandom_range(0, top);
         end else begin
            px.luma      = $urandom_range(0, 65536);
            px.blue_diff = int'($urandom_range(0, 65536)) - 32768;
            px.red_diff  = int'($urandom_range(0, 65536)) - 32768;
         end
      end
      return px;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_DIRECTION)
         cfg_direction = value[0];
      else
         cfg_max = value[15:0];
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (source_pixels.size() != 0 || req_valid || expected_pixels.size() != 0);
   endtask

   task automatic set_mode(logic dir, logic [15:0] max_value, int s_mode, int r_mode);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_DIRECTION, CSR_DATA_W'(dir));
      write_reg(REG_MAX_SAMPLE, CSR_DATA_W'(max_value));
      send_mode = s_mode;
      recv_mode = r_mode;
      @(negedge clock);
   endtask

   task automatic push_pixel(int r, int g, int b, int y, int pb, int pr);
      pixel_type px;
      px.red       = r;
      px.green     = g;
      px.blue      = b;
      px.luma      = y;
      px.blue_diff = pb;
      px.red_diff  = pr;
      source_pixels.push_back(px);
   endtask

   task automatic run_random(logic dir, logic [15:0] max_value, int count, int s_mode,
                             int r_mode);
      int left;
      int chunk;
      set_mode(dir, max_value, s_mode, r_mode);
      left = count;
      while (left > 0) begin
         chunk = $urandom_range(15, 60);
         if (chunk > left) chunk = left;
         @(negedge clock);
         repeat (chunk) source_pixels.push_back(random_pixel());
         left -= chunk;
         // on one chunk in three, at random, the sender holds off until the pipe has emptied
         if ($urandom_range(0, 2) == 0) wait_drained();
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_pixels.push_back(convert_pixel(on_wire));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (source_pixels.size() != 0) begin
               on_wire = source_pixels.pop_front();
               req_red_in       <= on_wire.red;
               req_green_in     <= on_wire.green;
               req_blue_in      <= on_wire.blue;
               req_luma_in      <= on_wire.luma;
               req_blue_diff_in <= on_wire.blue_diff;
               req_red_diff_in  <= on_wire.red_diff;
               req_valid        <= 1'b1;
               send_gap = draw_wait(send_mode);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_luma_out !== oldest.luma)
                  report_mismatch("luma_out", rsp_luma_out, oldest.luma);
               if (rsp_blue_diff_out !== oldest.blue_diff)
                  report_mismatch("blue_diff_out", rsp_blue_diff_out, oldest.blue_diff);
               if (rsp_red_diff_out !== oldest.red_diff)
                  report_mismatch("red_diff_out", rsp_red_diff_out, oldest.red_diff);
               if (rsp_red_out !== oldest.red)
                  report_mismatch("red_out", rsp_red_out, oldest.red);
               if (rsp_green_out !== oldest.green)
                  report_mismatch("green_out", rsp_green_out, oldest.green);
               if (rsp_blue_out !== oldest.blue)
                  report_mismatch("blue_out", rsp_blue_out, oldest.blue);
            end
            recv_hold = draw_wait(recv_mode);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // forward corners: black, white, primaries, saturation, rounding
      set_mode(1'b0, 16'd255, 0, 0);
      push_pixel(0, 0, 0, 0, 0, 0);
      push_pixel(255, 255, 255, 0, 0, 0);
      push_pixel(255, 0, 0, 0, 0, 0);
      push_pixel(0, 255, 0, 0, 0, 0);
      push_pixel(0, 0, 255, 0, 0, 0);
      push_pixel(65535, 65535, 65535, 0, 0, 0);
      push_pixel(65535, 0, 0, 0, 0, 0);
      push_pixel(0, 65535, 0, 0, 0, 0);
      push_pixel(128, 128, 128, 0, 0, 0);

      // inverse corners: zero, full scale, clamps, negative sums, tiny values
      set_mode(1'b1, 16'd255, 1, 1);
      push_pixel(0, 0, 0, 0, 0, 0);
      push_pixel(0, 0, 0, 65536, 0, 0);
      push_pixel(0, 0, 0, 32768, 0, 0);
      push_pixel(0, 0, 0, -131072, -131072, -131072);
      push_pixel(0, 0, 0, 131071, 131071, 131071);
      push_pixel(0, 0, 0, 65536, 0, 32768);
      push_pixel(0, 0, 0, 0, -32768, 0);
      push_pixel(0, 0, 0, 0, 32767, 0);
      push_pixel(0, 0, 0, 1, 0, 0);

      run_random(1'b0, 16'd255,   85, 0, 0);
      run_random(1'b0, 16'd1,     85, 1, 0);
      run_random(1'b0, 16'd65535, 85, 2, 0);
      run_random(1'b0, 16'd0,     85, 0, 1);
      run_random(1'b0, 16'($urandom_range(2, 65534)), 85, 1, 1);
      run_random(1'b1, 16'd255,   85, 2, 1);
      run_random(1'b1, 16'd1,     85, 0, 2);
      run_random(1'b1, 16'd65535, 85, 1, 2);
      run_random(1'b1, 16'd0,     85, 2, 2);
      run_random(1'b1, 16'($urandom_range(2, 65534)), 85, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rypc_pkg.sv
rtl/core/rypc_div_step.sv
rtl/core/rgb_ypbpr_color_converter_core.sv
bench/tb.sv
